// File: hw/rtl/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
// Used by gsa_ctrl, gsa_datapath and generational_slot_allocator; no dependencies.
`default_nettype none

package gsa_pkg;

    localparam int SLOTS        = 64;
    localparam int VERSION_BITS = 16;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int POS_W        = 16;
    localparam int KIND_W       = 2;
    localparam int FUNC_W       = 3;

    localparam logic [FUNC_W-1:0] FN_ALLOC    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_VALIDATE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FREE_ALL = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SET_POS  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_FIND     = 3'd5;

    localparam logic [2:0] FIN_NONE     = 3'd0;
    localparam logic [2:0] FIN_ALLOC    = 3'd1;
    localparam logic [2:0] FIN_FIND     = 3'd2;
    localparam logic [2:0] FIN_FREE     = 3'd3;
    localparam logic [2:0] FIN_VALIDATE = 3'd4;
    localparam logic [2:0] FIN_CLEAR    = 3'd5;
    localparam logic [2:0] FIN_SET_POS  = 3'd6;

    localparam logic [1:0] SRC_ZERO  = 2'd0;
    localparam logic [1:0] SRC_HINT  = 2'd1;
    localparam logic [1:0] SRC_INDEX = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [IDX_W-1:0]        slot_index;
        logic [VERSION_BITS-1:0] handle_version;
        logic [KIND_W-1:0]       kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } gsa_req_t;

    typedef struct packed {
        logic                    ok;
        logic [IDX_W-1:0]        out_index;
        logic [VERSION_BITS-1:0] out_version;
        logic [KIND_W-1:0]       out_kind;
        logic [CNT_W-1:0]        live_count;
    } gsa_rsp_t;

    typedef struct packed {
        logic       load_req;
        logic       scan_load;
        logic [1:0] scan_src;
        logic       scan_run;
        logic       finish;
        logic [2:0] fin_op;
    } gsa_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              hit;
        logic              exhausted;
    } gsa_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/generational_slot_allocator.sv
// Generational slot allocator: a pool of 64 slots handed out as index and version handles.
// Top level; depends on gsa_pkg, gsa_ctrl and gsa_datapath.
//
// A request is taken when start is high and busy is low; one result per request appears on
// rsp for exactly one cycle with rsp_valid high, and the receiver cannot stall it. Free all,
// set position and unused codes finish straight from dispatch; free and validate first read
// the indexed slot; allocate and find scan the slot tables, from the hint or from slot zero,
// until a match or the end of the pool. The scan examines one slot per cycle through the
// registered read port of the slot tables. busy drops in the cycle the result is shown, so
// the next request can be taken then.
`default_nettype none

module generational_slot_allocator
    import gsa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire gsa_req_t req,
    output logic          rsp_valid,
    output gsa_rsp_t      rsp
);

    gsa_cmd_t    cmd;
    gsa_status_t status;

    gsa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    gsa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: hw/rtl/gsa_datapath.sv
// Datapath of the slot allocator: slot tables, counters, scan pointer and result register.
// Depends on gsa_pkg; driven by commands from gsa_ctrl.
`default_nettype none

module gsa_datapath
    import gsa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire gsa_req_t req,
    input  wire gsa_cmd_t cmd,
    output gsa_status_t  status,
    output logic         rsp_valid,
    output gsa_rsp_t     rsp
);

    logic [VERSION_BITS-1:0] ver_mem [SLOTS];
    logic [KIND_W-1:0]       kind_mem [SLOTS];
    logic [2*POS_W-1:0]      pos_mem [SLOTS];

    gsa_req_t                req_reg;
    logic [SLOTS-1:0]        reserved_reg, reserved_next;
    logic [SLOTS-1:0]        ver_valid_reg, ver_valid_next;
    logic [CNT_W-1:0]        live_reg, live_next;
    logic [CNT_W-1:0]        hint_reg, hint_next;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [VERSION_BITS-1:0] rd_ver_reg;
    logic                    rd_ver_ok_reg;
    logic [KIND_W-1:0]       rd_kind_reg;
    logic [2*POS_W-1:0]      rd_pos_reg;
    logic                    rsp_valid_reg;
    gsa_rsp_t                rsp_reg, rsp_next;

    logic                    issue;
    logic [IDX_W-1:0]        rd_addr;
    logic                    rd_reserved;
    logic [VERSION_BITS-1:0] rd_ver;
    logic                    pos_match;
    logic                    in_range;
    logic                    idx_reserved;
    logic                    ver_we, kind_we, pos_we;
    logic [IDX_W-1:0]        wr_addr;
    logic [VERSION_BITS-1:0] ver_wdata;
    logic [2*POS_W-1:0]      pos_wdata;

    assign issue        = cmd.scan_run && (scan_reg < CNT_W'(SLOTS));
    assign rd_addr      = scan_reg[IDX_W-1:0];
    assign rd_reserved  = reserved_reg[rd_idx_reg];
    assign rd_ver       = rd_ver_ok_reg ? rd_ver_reg : '0;
    assign pos_match    = rd_pos_reg == {req_reg.pos_x, req_reg.pos_y};
    assign in_range     = CNT_W'(req_reg.slot_index) < CNT_W'(SLOTS);
    assign idx_reserved = reserved_reg[req_reg.slot_index];

    assign status.func      = req_reg.func;
    assign status.hit       = rd_valid_reg && ((req_reg.func == FN_ALLOC) ? !rd_reserved
                                                             : (rd_reserved && pos_match));
    assign status.exhausted = !rd_valid_reg && (scan_reg == CNT_W'(SLOTS));

    always_comb
    begin
        scan_next = scan_reg;
        if (cmd.scan_load)
        begin
            case (cmd.scan_src)
                SRC_HINT:  scan_next = hint_reg;
                SRC_INDEX: scan_next = CNT_W'(req_reg.slot_index);
                default:   scan_next = '0;
            endcase
        end
        else if (issue)
        begin
            scan_next = scan_reg + CNT_W'(1);
        end
        rd_valid_next = issue;
    end

    always_comb
    begin
        reserved_next  = reserved_reg;
        ver_valid_next = ver_valid_reg;
        live_next      = live_reg;
        hint_next      = hint_reg;
        rsp_next       = '0;
        ver_we         = 1'b0;
        kind_we        = 1'b0;
        pos_we         = 1'b0;
        wr_addr        = rd_idx_reg;
        ver_wdata      = rd_ver + VERSION_BITS'(1);
        pos_wdata      = '0;
        if (cmd.finish)
        begin
            case (cmd.fin_op)
                FIN_ALLOC:
                begin
                    reserved_next[rd_idx_reg]  = 1'b1;
                    ver_valid_next[rd_idx_reg] = 1'b1;
                    live_next           = live_reg + CNT_W'(1);
                    hint_next           = CNT_W'(rd_idx_reg) + CNT_W'(1);
                    ver_we              = 1'b1;
                    kind_we             = 1'b1;
                    pos_we              = 1'b1;
                    rsp_next.ok         = 1'b1;
                    rsp_next.out_index  = rd_idx_reg;
                    rsp_next.out_version = ver_wdata;
                    rsp_next.out_kind   = req_reg.kind;
                end
                FIN_FIND:
                begin
                    rsp_next.ok          = 1'b1;
                    rsp_next.out_index   = rd_idx_reg;
                    rsp_next.out_version = rd_ver;
                    rsp_next.out_kind    = rd_kind_reg;
                end
                FIN_FREE:
                begin
                    if (in_range && idx_reserved)
                    begin
                        reserved_next[req_reg.slot_index] = 1'b0;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - CNT_W'(1);
                        end
                        if (CNT_W'(req_reg.slot_index) < hint_reg)
                        begin
                            hint_next = CNT_W'(req_reg.slot_index);
                        end
                        rsp_next.ok       = 1'b1;
                        rsp_next.out_kind = rd_kind_reg;
                    end
                end
                FIN_VALIDATE:
                begin
                    if (in_range && (req_reg.handle_version != '0) && idx_reserved
                        && (rd_ver == req_reg.handle_version))
                    begin
                        rsp_next.ok       = 1'b1;
                        rsp_next.out_kind = rd_kind_reg;
                    end
                end
                FIN_CLEAR:
                begin
                    reserved_next = '0;
                    live_next     = '0;
                    hint_next     = '0;
                    rsp_next.ok   = 1'b1;
                end
                FIN_SET_POS:
                begin
                    if (in_range)
                    begin
                        pos_we      = 1'b1;
                        wr_addr     = req_reg.slot_index;
                        pos_wdata   = {req_reg.pos_x, req_reg.pos_y};
                        rsp_next.ok = 1'b1;
                    end
                end
                default:
                begin
                    rsp_next.ok = 1'b0;
                end
            endcase
        end
        rsp_next.live_count = live_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg  <= '0;
            ver_valid_reg <= '0;
            live_reg      <= '0;
            hint_reg      <= '0;
            scan_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            reserved_reg  <= reserved_next;
            ver_valid_reg <= ver_valid_next;
            live_reg      <= live_next;
            hint_reg      <= hint_next;
            scan_reg      <= scan_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
        rd_idx_reg <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (ver_we)
        begin
            ver_mem[wr_addr] <= ver_wdata;
        end
        if (kind_we)
        begin
            kind_mem[wr_addr] <= req_reg.kind;
        end
        if (pos_we)
        begin
            pos_mem[wr_addr] <= pos_wdata;
        end
        rd_ver_reg    <= ver_mem[rd_addr];
        rd_kind_reg   <= kind_mem[rd_addr];
        rd_pos_reg    <= pos_mem[rd_addr];
        rd_ver_ok_reg <= ver_valid_reg[rd_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The live count always matches the number of reserved slots.
    a_live_matches: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg == CNT_W'($countones(reserved_reg)))
        else $error("live count differs from reserved slots");

    a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hint_reg <= CNT_W'(SLOTS)) && (scan_reg <= CNT_W'(SLOTS)))
        else $error("hint or scan pointer beyond the pool");

    // Every reserved slot has had its version written.
    a_reserved_has_version: assert property (@(posedge clk) disable iff (!rst_n)
        (reserved_reg & ~ver_valid_reg) == '0)
        else $error("reserved slot without a written version");

    a_rsp_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |=> !rsp_valid_reg)
        else $error("two results in consecutive cycles");

endmodule

`default_nettype wire

// File: hw/rtl/gsa_ctrl.sv
// Controller state machine of the slot allocator: sequences each request.
// Depends on gsa_pkg; commands gsa_datapath and reads its status.
`default_nettype none

module gsa_ctrl
    import gsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire gsa_status_t status,
    output gsa_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_LOOK     = 3'd3;
    localparam logic [2:0] ST_CHECK    = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.func)
                    FN_ALLOC:
                    begin
                        cmd.scan_load = 1'b1;
                        cmd.scan_src  = SRC_HINT;
                        state_next    = ST_SCAN;
                    end
                    FN_FIND:
                    begin
                        cmd.scan_load = 1'b1;
                        cmd.scan_src  = SRC_ZERO;
                        state_next    = ST_SCAN;
                    end
                    FN_FREE, FN_VALIDATE:
                    begin
                        cmd.scan_load = 1'b1;
                        cmd.scan_src  = SRC_INDEX;
                        state_next    = ST_LOOK;
                    end
                    FN_FREE_ALL:
                    begin
                        cmd.finish = 1'b1;
                        cmd.fin_op = FIN_CLEAR;
                        state_next = ST_IDLE;
                    end
                    FN_SET_POS:
                    begin
                        cmd.finish = 1'b1;
                        cmd.fin_op = FIN_SET_POS;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        cmd.fin_op = FIN_NONE;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.hit)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_op = (status.func == FN_ALLOC) ? FIN_ALLOC : FIN_FIND;
                    state_next = ST_IDLE;
                end
                else if (status.exhausted)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_op = FIN_NONE;
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK:
            begin
                cmd.scan_run = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.finish = 1'b1;
                cmd.fin_op = (status.func == FN_FREE) ? FIN_FREE : FIN_VALIDATE;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != ST_IDLE;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && state_reg == ST_DISPATCH))
        else $error("accepted request did not start");

    a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy)
        else $error("controller stayed busy after a result");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_req || cmd.scan_load) |-> !cmd.finish)
        else $error("request load and finish in the same cycle");

endmodule

`default_nettype wire

// File: tb/gsa_response_checker.sv
// Response checker for the generational slot allocator: watches the request and result
// channels, keeps its own copy of the slot pool and compares every result with its prediction.
// Depends on gsa_pkg for the request and result types and the operation codes.
`timescale 1ns / 1ps

module gsa_response_checker
    import gsa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     busy,
    input  wire gsa_req_t req,
    input  wire logic     rsp_valid,
    input  wire gsa_rsp_t rsp,
    output int            errors,
    output int            pending
);

    logic                    held [SLOTS];
    logic [VERSION_BITS-1:0] slot_ver [SLOTS];
    logic [KIND_W-1:0]       slot_kind [SLOTS];
    logic signed [POS_W-1:0] slot_px [SLOTS];
    logic signed [POS_W-1:0] slot_py [SLOTS];
    logic [CNT_W-1:0]        live_slots;
    logic [CNT_W-1:0]        free_hint;

    gsa_rsp_t expected_rsps[$];
    gsa_rsp_t want;
    int       mismatches = 0;
    int       n;

    assign errors = mismatches;

    function automatic gsa_rsp_t predict_slot_op(input gsa_req_t r);
        gsa_rsp_t a;
        int i;
        a = '0;
        case (r.func)
            FN_ALLOC:
            begin
                for (i = int'(free_hint); i < SLOTS; i++)
                begin
                    if (!a.ok && !held[i])
                    begin
                        held[i] = 1'b1;
                        slot_ver[i] = slot_ver[i] + 1'b1;
                        slot_kind[i] = r.kind;
                        slot_px[i] = '0;
                        slot_py[i] = '0;
                        live_slots = live_slots + 1'b1;
                        free_hint = CNT_W'(i + 1);
                        a.ok = 1'b1;
                        a.out_index = IDX_W'(i);
                        a.out_version = slot_ver[i];
                        a.out_kind = r.kind;
                    end
                end
            end
            FN_FREE:
            begin
                if (held[r.slot_index])
                begin
                    held[r.slot_index] = 1'b0;
                    if (live_slots != '0)
                        live_slots = live_slots - 1'b1;
                    if (CNT_W'(r.slot_index) < free_hint)
                        free_hint = CNT_W'(r.slot_index);
                    a.ok = 1'b1;
                    a.out_kind = slot_kind[r.slot_index];
                end
            end
            FN_VALIDATE:
            begin
                if (r.handle_version != '0 && held[r.slot_index] &&
                    slot_ver[r.slot_index] == r.handle_version)
                begin
                    a.ok = 1'b1;
                    a.out_kind = slot_kind[r.slot_index];
                end
            end
            FN_FREE_ALL:
            begin
                for (i = 0; i < SLOTS; i++)
                    held[i] = 1'b0;
                live_slots = '0;
                free_hint = '0;
                a.ok = 1'b1;
            end
            FN_SET_POS:
            begin
                slot_px[r.slot_index] = r.pos_x;
                slot_py[r.slot_index] = r.pos_y;
                a.ok = 1'b1;
            end
            FN_FIND:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (!a.ok && held[i] && slot_px[i] == r.pos_x && slot_py[i] == r.pos_y)
                    begin
                        a.ok = 1'b1;
                        a.out_index = IDX_W'(i);
                        a.out_version = slot_ver[i];
                        a.out_kind = slot_kind[i];
                    end
                end
            end
            default:
            begin
            end
        endcase
        a.live_count = live_slots;
        return a;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (n = 0; n < SLOTS; n++)
            begin
                held[n] = 1'b0;
                slot_ver[n] = '0;
                slot_kind[n] = '0;
                slot_px[n] = '0;
                slot_py[n] = '0;
            end
            live_slots = '0;
            free_hint = '0;
            expected_rsps.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp_valid)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, expected none, actual %h",
                             $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("ok", 16'(want.ok), 16'(rsp.ok));
                    check_field("out_index", 16'(want.out_index), 16'(rsp.out_index));
                    check_field("out_version", want.out_version, rsp.out_version);
                    check_field("out_kind", 16'(want.out_kind), 16'(rsp.out_kind));
                    check_field("live_count", 16'(want.live_count), 16'(rsp.live_count));
                end
            end
            if (start && !busy)
                expected_rsps.push_back(predict_slot_op(req));
            pending <= expected_rsps.size();
        end
    end

endmodule

// File: tb/generational_slot_allocator_test.sv
// Testbench top for the generational slot allocator: drives directed, reallocation, pool-full
// and random request sequences and gives the verdict. Depends on gsa_pkg, the block itself
// and gsa_response_checker, which predicts and compares every result.
`timescale 1ns / 1ps

module generational_slot_allocator_test;
    import gsa_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 150;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    gsa_req_t req;
    logic     rsp_valid;
    gsa_rsp_t rsp;
    int       errors;
    int       pending;
    int       quiet_cycles = 0;
    int       idle_pct = 0;
    int       gap_pct [4] = '{0, 54, 0, 12};

    logic [IDX_W+VERSION_BITS-1:0] known_handles[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    generational_slot_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    gsa_response_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    always @(posedge clk)
    begin
        if (rsp_valid)
        begin
            if (rsp.ok && rsp.out_version != '0)
            begin
                known_handles.push_back({rsp.out_index, rsp.out_version});
                if (known_handles.size() > 48)
                    void'(known_handles.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((start && !busy) || rsp_valid))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

    function automatic gsa_req_t make_req(input logic [FUNC_W-1:0] func,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [VERSION_BITS-1:0] ver,
                                          input logic [KIND_W-1:0] kind,
                                          input logic signed [POS_W-1:0] x,
                                          input logic signed [POS_W-1:0] y);
        gsa_req_t r;
        r.func = func;
        r.slot_index = idx;
        r.handle_version = ver;
        r.kind = kind;
        r.pos_x = x;
        r.pos_y = y;
        return r;
    endfunction

    function automatic gsa_req_t random_noise();
        return make_req(FUNC_W'($urandom), IDX_W'($urandom), VERSION_BITS'($urandom),
                        KIND_W'($urandom), POS_W'($urandom), POS_W'($urandom));
    endfunction

    function automatic logic signed [POS_W-1:0] pick_coord();
        case ($urandom_range(7))
            0: return 16'sd0;
            1: return 16'sd1;
            2: return -16'sd1;
            3: return 16'sh7FFF;
            4: return 16'sh8000;
            5: return 16'sd100;
            default: return POS_W'($urandom);
        endcase
    endfunction

    task automatic send(input gsa_req_t r);
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            req <= random_noise();
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_request(output gsa_req_t r);
        int unsigned pick;
        logic [IDX_W+VERSION_BITS-1:0] h;
        r = random_noise();
        pick = $urandom_range(99);
        h = {IDX_W'($urandom), VERSION_BITS'($urandom)};
        if (known_handles.size() != 0 && $urandom_range(3) != 0)
            h = known_handles[$urandom_range(known_handles.size() - 1)];
        if (pick < 32)
        begin
            r.func = FN_ALLOC;
        end
        else if (pick < 70)
        begin
            r.func = (pick < 52) ? FN_FREE : FN_VALIDATE;
            r.slot_index = h[IDX_W+VERSION_BITS-1 -: IDX_W];
            r.handle_version = h[VERSION_BITS-1:0];
        end
        else if (pick < 82)
        begin
            r.func = FN_SET_POS;
            r.slot_index = h[IDX_W+VERSION_BITS-1 -: IDX_W];
            r.pos_x = pick_coord();
            r.pos_y = pick_coord();
        end
        else if (pick < 94)
        begin
            r.func = FN_FIND;
            r.pos_x = pick_coord();
            r.pos_y = pick_coord();
        end
        else if (pick < 97)
        begin
            r.func = $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
        end
        else
        begin
            r.func = FN_FREE_ALL;
        end
    endtask

    initial
    begin
        gsa_req_t    r;
        int          phase;

        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send(make_req(FN_VALIDATE, 0, 1, 0, 0, 0));
        send(make_req(FN_FREE, 5, 0, 0, 0, 0));
        send(make_req(FN_FIND, 0, 0, 0, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 0, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 1, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 2, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 3, 0, 0));
        send(make_req(FN_SET_POS, 1, 0, 0, 16'sh7FFF, 16'sh8000));
        send(make_req(FN_SET_POS, 40, 16'hFFFF, 3, -16'sd1, 16'sh7FFF));
        send(make_req(FN_FIND, 0, 0, 0, 16'sh7FFF, 16'sh8000));
        send(make_req(FN_FIND, 0, 0, 0, 0, 0));
        send(make_req(FN_FIND, 0, 0, 0, -16'sd1, 16'sh7FFF));
        send(make_req(FN_VALIDATE, 1, 1, 0, 0, 0));
        send(make_req(FN_VALIDATE, 1, 16'hFFFF, 0, 0, 0));
        send(make_req(FN_VALIDATE, 2, 0, 0, 0, 0));
        send(make_req(FN_FREE, 1, 16'hFFFF, 0, 0, 0));
        send(make_req(FN_FREE, 1, 1, 0, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 2, 0, 0));
        send(make_req(FN_SPARE_A, 1, 1, 1, 1, 1));
        send(make_req(FN_SPARE_B, 63, 16'hFFFF, 3, -16'sd1, -16'sd1));
        send(make_req(FN_SET_POS, 63, 16'hFFFF, 3, -16'sd1, -16'sd1));
        send(make_req(FN_FREE_ALL, 0, 0, 0, 0, 0));
        send(make_req(FN_VALIDATE, 0, 1, 0, 0, 0));

        // Reallocate slot 0 several times so that its version moves on and older handles to
        // it stop validating.
        send(make_req(FN_FREE_ALL, 0, 0, 0, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 3, 0, 0));
        repeat (4)
        begin
            send(make_req(FN_FREE_ALL, 0, 0, 0, 0, 0));
            send(make_req(FN_ALLOC, 0, 0, 3, 0, 0));
        end
        send(make_req(FN_FREE_ALL, 0, 0, 0, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 1, 0, 0));
        send(make_req(FN_VALIDATE, 0, 0, 0, 0, 0));
        send(make_req(FN_VALIDATE, 0, 16'hFFFF, 0, 0, 0));
        send(make_req(FN_FREE, 0, 0, 0, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 2, 0, 0));
        send(make_req(FN_VALIDATE, 0, 1, 0, 0, 0));
        drain();

        // Fill the pool past its end, then reuse freed holes below the hint.
        send(make_req(FN_FREE_ALL, 0, 0, 0, 0, 0));
        repeat (SLOTS + 1)
            send(make_req(FN_ALLOC, 0, 0, KIND_W'($urandom), 0, 0));
        send(make_req(FN_SET_POS, 63, 0, 0, 16'sh8000, 16'sh7FFF));
        send(make_req(FN_FIND, 0, 0, 0, 16'sh8000, 16'sh7FFF));
        send(make_req(FN_FIND, 0, 0, 0, 16'sd1234, -16'sd1234));
        send(make_req(FN_FREE, 20, 0, 0, 0, 0));
        send(make_req(FN_FREE, 10, 0, 0, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 1, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 2, 0, 0));
        send(make_req(FN_ALLOC, 0, 0, 0, 0, 0));
        send(make_req(FN_FREE_ALL, 0, 0, 0, 0, 0));
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = gap_pct[phase];
            repeat (PHASE_ITEMS)
            begin
                random_request(r);
                send(r);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
